>>> rtl/pld_pkg.sv
// ----------------------------------------------------------------------------
// pld_pkg
// Shared types and constants for the preamble / length packet deframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pld_pkg;

  // default payload store depth
  localparam int MaxPayloadDefault = 32;

  // field widths
  localparam int ByteW  = 8;
  localparam int IndexW = 5;
  localparam int LenW   = 6;
  localparam int TmoW   = 16;
  localparam int IdleW  = 17;

  // configuration port
  localparam int AddrW = 4;
  localparam int DataW = 32;

  // register indexes (word address bits)
  localparam logic [1:0] REG_PREAMBLE = 2'd0;
  localparam logic [1:0] REG_MAX_LEN  = 2'd1;
  localparam logic [1:0] REG_TIMEOUT  = 2'd2;

  // reset values of the registers
  localparam logic [ByteW-1:0] PreambleReset = 8'd0;
  localparam logic [LenW-1:0]  MaxLenReset   = 6'd32;
  localparam logic [TmoW-1:0]  TimeoutReset  = 16'd100;

  // input item kinds
  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef struct packed {
    logic             mode;
    logic [ByteW-1:0] rx_byte;
  } pld_in_t;

  typedef struct packed {
    logic [ByteW-1:0]  out_byte;
    logic [IndexW-1:0] out_index;
    logic [LenW-1:0]   packet_length;
    logic              last;
  } pld_out_t;

  typedef struct packed {
    logic [ByteW-1:0] preamble_value;
    logic [LenW-1:0]  max_length;
    logic [TmoW-1:0]  timeout_ticks;
  } pld_cfg_t;

  typedef enum logic [1:0] {
    ST_HUNT,
    ST_LEN,
    ST_DATA,
    ST_EMIT
  } pld_state_t;

  // controller to datapath
  typedef struct packed {
    logic tick_inc;
    logic idle_clr;
    logic len_load;
    logic fill_clr;
    logic fill_store;
    logic emit_clr;
    logic emit_load;
  } pld_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_preamble;
    logic timed_out;
    logic len_ok;
    logic fill_last;
    logic emit_last;
    logic out_free;
  } pld_stat_t;

endpackage

`default_nettype wire

>>> rtl/pld_regs.sv
// ----------------------------------------------------------------------------
// pld_regs
// APB-style configuration registers: preamble, maximum length, timeout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pld_regs (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [pld_pkg::AddrW-1:0] paddr,
  input  wire logic [pld_pkg::DataW-1:0] pwdata,
  output logic      [pld_pkg::DataW-1:0] prdata,
  output logic                           pready,
  output pld_pkg::pld_cfg_t              cfg
);
  import pld_pkg::*;

  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.preamble_value <= PreambleReset;
      cfg.max_length     <= MaxLenReset;
      cfg.timeout_ticks  <= TimeoutReset;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_PREAMBLE: cfg.preamble_value <= pwdata[ByteW-1:0];
        REG_MAX_LEN:  cfg.max_length     <= pwdata[LenW-1:0];
        REG_TIMEOUT:  cfg.timeout_ticks  <= pwdata[TmoW-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (reg_sel)
      REG_PREAMBLE: prdata = {{(DataW-ByteW){1'b0}}, cfg.preamble_value};
      REG_MAX_LEN:  prdata = {{(DataW-LenW){1'b0}}, cfg.max_length};
      REG_TIMEOUT:  prdata = {{(DataW-TmoW){1'b0}}, cfg.timeout_ticks};
      default:      prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/pld_dp.sv
// ----------------------------------------------------------------------------
// pld_dp
// Deframer datapath: idle tick counter, length, fill and emit counters, payload
// store, and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pld_dp #(
  parameter int MAX_PAYLOAD = pld_pkg::MaxPayloadDefault
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire pld_pkg::pld_cfg_t         cfg,
  input  wire logic [pld_pkg::ByteW-1:0] rx_byte,
  input  wire pld_pkg::pld_cmd_t         cmd,
  output pld_pkg::pld_stat_t             stat,
  output logic                           result_valid,
  input  wire logic                      result_stall,
  output pld_pkg::pld_out_t              result
);
  import pld_pkg::*;

  // lengths never exceed what the 6-bit length register can hold
  localparam int LenMax = (1 << LenW) - 1;
  localparam int Depth  = (MAX_PAYLOAD < LenMax) ? MAX_PAYLOAD : LenMax;
  localparam int AW     = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [ByteW-1:0] MaxPayloadB = ByteW'(MAX_PAYLOAD);
  localparam logic [IdleW-1:0] IdleMax     = '1;

  logic [IdleW-1:0] idle_ticks;
  logic [LenW-1:0]  expected_length;
  logic [LenW-1:0]  fill_count;
  logic [LenW-1:0]  emit_idx;
  logic [LenW-1:0]  fill_inc;
  logic [LenW-1:0]  emit_inc;
  logic [ByteW-1:0] payload_store [Depth];

  assign fill_inc = fill_count + LenW'(1);
  assign emit_inc = emit_idx + LenW'(1);

  // status to the controller
  assign stat.is_preamble = (rx_byte == cfg.preamble_value);
  assign stat.timed_out   = (idle_ticks > {1'b0, cfg.timeout_ticks});
  assign stat.len_ok      = (rx_byte != '0) && (rx_byte <= MaxPayloadB) &&
                            (rx_byte <= {{(ByteW-LenW){1'b0}}, cfg.max_length});
  assign stat.fill_last   = (fill_inc == expected_length);
  assign stat.emit_last   = (emit_inc == expected_length);
  assign stat.out_free    = !result_valid || !result_stall;

  // saturating idle tick counter
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_ticks <= '0;
    end else if (cmd.idle_clr) begin
      idle_ticks <= '0;
    end else if (cmd.tick_inc && idle_ticks != IdleMax) begin
      idle_ticks <= idle_ticks + IdleW'(1);
    end
  end

  // frame length and fill / emit counters
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_length <= '0;
      fill_count      <= '0;
      emit_idx        <= '0;
    end else begin
      if (cmd.len_load) begin
        expected_length <= rx_byte[LenW-1:0];
      end
      if (cmd.fill_clr) begin
        fill_count <= '0;
      end else if (cmd.fill_store) begin
        fill_count <= fill_inc;
      end
      if (cmd.emit_clr) begin
        emit_idx <= '0;
      end else if (cmd.emit_load) begin
        emit_idx <= emit_inc;
      end
    end
  end

  // payload store write port
  always_ff @(posedge clk) begin
    if (cmd.fill_store) begin
      payload_store[fill_count[AW-1:0]] <= rx_byte;
    end
  end

  // result register, loaded straight from the store read port
  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      result.out_byte      <= payload_store[emit_idx[AW-1:0]];
      result.out_index     <= emit_idx[IndexW-1:0];
      result.packet_length <= expected_length;
      result.last          <= stat.emit_last;
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> rtl/pld_ctrl.sv
// ----------------------------------------------------------------------------
// pld_ctrl
// Deframer controller: hunt, length, payload and emit phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pld_ctrl (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         item_valid,
  input  wire logic         mode,
  input  wire pld_pkg::pld_stat_t stat,
  output pld_pkg::pld_cmd_t  cmd,
  output logic               item_stall
);
  import pld_pkg::*;

  pld_state_t state;
  pld_state_t state_next;
  logic       xfer;
  logic       is_byte;

  assign item_stall = (state == ST_EMIT);
  assign xfer       = item_valid && !item_stall;
  assign is_byte    = xfer && (mode == MODE_BYTE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_HUNT;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.tick_inc = xfer && (mode == MODE_TICK);

    unique case (state)
      ST_HUNT: begin
        if (is_byte) begin
          cmd.fill_clr = 1'b1;
          if (stat.is_preamble) begin
            cmd.idle_clr = 1'b1;
            state_next   = ST_LEN;
          end
        end
      end
      ST_LEN: begin
        if (is_byte) begin
          cmd.fill_clr = 1'b1;
          cmd.idle_clr = 1'b1;
          if (stat.timed_out) begin
            // stale frame: judge this byte as a possible preamble
            state_next = stat.is_preamble ? ST_LEN : ST_HUNT;
          end else if (stat.len_ok) begin
            cmd.len_load = 1'b1;
            state_next   = ST_DATA;
          end else begin
            state_next = ST_HUNT;
          end
        end
      end
      ST_DATA: begin
        if (is_byte) begin
          cmd.idle_clr = 1'b1;
          if (stat.timed_out) begin
            cmd.fill_clr = 1'b1;
            state_next   = stat.is_preamble ? ST_LEN : ST_HUNT;
          end else begin
            cmd.fill_store = 1'b1;
            if (stat.fill_last) begin
              cmd.fill_clr = 1'b1;
              cmd.emit_clr = 1'b1;
              state_next   = ST_EMIT;
            end
          end
        end
      end
      ST_EMIT: begin
        // one payload byte per free output slot
        if (stat.out_free) begin
          cmd.emit_load = 1'b1;
          if (stat.emit_last) begin
            state_next = ST_HUNT;
          end
        end
      end
      default: state_next = ST_HUNT;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/preamble_length_packet_deframer.sv
// ----------------------------------------------------------------------------
// preamble_length_packet_deframer
// Receives preamble / length / payload frames from a byte-and-tick stream and
// delivers each completed packet one payload byte per result.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid / item_stall / item): each transfer is either a
//   received byte (mode 0) or a one millisecond tick (mode 1). Bytes and
//   ticks are taken one per cycle while a frame is being collected.
//   result channel (result_valid / result_stall / result): one transfer per
//   payload byte of a completed frame, in order, last set on the final one.
//   The first result of a packet is valid once the controller has entered
//   its emit phase and loaded the result register; further results follow
//   one per cycle unless the receiver stalls the result register. While a
//   packet is read out of the payload store (one read port) item_stall is
//   high. The last result may still wait in the result register while new
//   items are taken. Configuration must be written through the APB-style
//   port only while idle; the block itself does not enforce this.
//   Reset: synchronous, active high; the block hunts for a preamble with
//   cleared counters and registers at their reset values. The payload store
//   is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module preamble_length_packet_deframer #(
  parameter int MAX_PAYLOAD = pld_pkg::MaxPayloadDefault
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  // item channel
  input  wire logic                      item_valid,
  output logic                           item_stall,
  input  wire pld_pkg::pld_in_t          item,
  // result channel
  output logic                           result_valid,
  input  wire logic                      result_stall,
  output pld_pkg::pld_out_t              result,
  // configuration port
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [pld_pkg::AddrW-1:0] paddr,
  input  wire logic [pld_pkg::DataW-1:0] pwdata,
  output logic      [pld_pkg::DataW-1:0] prdata,
  output logic                           pready
);
  import pld_pkg::*;

  pld_cfg_t  cfg;
  pld_cmd_t  cmd;
  pld_stat_t stat;

  // configuration registers
  pld_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // phase sequencing
  pld_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .mode       (item.mode),
    .stat       (stat),
    .cmd        (cmd),
    .item_stall (item_stall)
  );

  // counters, payload store, result register
  pld_dp #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .rx_byte      (item.rx_byte),
    .cmd          (cmd),
    .stat         (stat),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire

>>> rtl/pld_checker.sv
// ----------------------------------------------------------------------------
// pld_checker
// Port-level checks for the deframer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pld_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              item_stall,
  input wire logic              result_valid,
  input wire logic              result_stall,
  input wire pld_pkg::pld_out_t result
);
  import pld_pkg::*;

  // a stalled result holds its payload
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // reset leaves no result pending and the item channel open
  assert property (@(posedge clk)
    rst |=> !result_valid && !item_stall)
    else $error("block not idle after reset");

  // last is flagged exactly on the final index of the packet
  assert property (@(posedge clk) disable iff (rst)
    result_valid |->
      (result.last == (result.out_index == IndexW'(result.packet_length - LenW'(1)))))
    else $error("last flag disagrees with index and length");

  // a delivered packet never has zero length
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.packet_length != '0)
    else $error("result with zero packet length");

endmodule

bind preamble_length_packet_deframer pld_checker u_pld_checker (
  .clk          (clk),
  .rst          (rst),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

`default_nettype wire
